/* hdl/disjoint_set_wall_carver_defines.svh */
// assertion macros used by the carver rtl
`ifndef DISJOINT_SET_WALL_CARVER_DEFINES_SVH
`define DISJOINT_SET_WALL_CARVER_DEFINES_SVH

// property must hold at every clock edge outside reset
`define DSWC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// expression must never be true outside reset
`define DSWC_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

/* hdl/dswc_pkg.sv */
package dswc_pkg;

	localparam int CELL_W        = 10;
	localparam int MAX_CELLS_DEF = 1024;

	// one input transfer
	typedef struct packed {
		logic              mode;
		logic [CELL_W-1:0] cell_a;
		logic [CELL_W-1:0] cell_b;
	} dswc_cmd_t;

	// one result transfer
	typedef struct packed {
		logic              carved;
		logic [CELL_W-1:0] carved_cell;
		logic              wall_dir;
	} dswc_res_t;

	localparam logic MODE_CLEAR = 1'b0;
	localparam logic MODE_WALL  = 1'b1;

	localparam logic DIR_EAST  = 1'b0;
	localparam logic DIR_SOUTH = 1'b1;

endpackage

/* hdl/dswc_parent_ram.sv */
module dswc_parent_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [AW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [AW-1:0] rdata
);

	logic [AW-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hdl/disjoint_set_wall_carver.sv */
// order of work: a clear item sweeps every table entry and then gives its result; a wall
//   item walks cell_a up to its root, then cell_b up to its root; out-of-range wall: result from idle
// throughput: one item at a time; each parent link step takes a read state and a check
//   state, set by the single read port of the parent memory and its registered read
// reset: the clearing pass writes every entry with busy high, no result is given
// results appear on done for one cycle; the receiver cannot stall
`include "disjoint_set_wall_carver_defines.svh"

module disjoint_set_wall_carver #(
	parameter int MAX_CELLS = dswc_pkg::MAX_CELLS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  dswc_pkg::dswc_cmd_t item,
	output logic                done,
	output dswc_pkg::dswc_res_t result
);

	import dswc_pkg::*;

	localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_A,
		ST_CK_A,
		ST_RD_B,
		ST_CK_B
	} state_t;

	state_t        state_q;
	logic [AW-1:0] cnt_q;       // clearing sweep address
	logic          clr_item_q;  // sweep was started by a clear item, not by reset
	logic [AW-1:0] node_q;      // current node of the root walk
	logic [AW-1:0] root_a_q;    // root found for cell_a
	dswc_cmd_t     item_q;
	logic          done_q;
	dswc_res_t     res_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_wdata;
	logic [AW-1:0] ram_rdata;

	logic          accept;
	logic          in_range;
	logic          at_root;
	logic          link;
	logic          east;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign result = res_q;

	// cells beyond the table leave it untouched
	assign in_range = (32'(item.cell_a) < 32'(MAX_CELLS)) && (32'(item.cell_b) < 32'(MAX_CELLS));

	// read data is valid in the check states, in the cycle after the read state
	assign at_root = (ram_rdata == node_q);
	assign link    = (state_q == ST_CK_B) && at_root && (node_q != root_a_q);
	assign east    = ({1'b0, item_q.cell_b} == ({1'b0, item_q.cell_a} + (CELL_W+1)'(1)));

	// write port: identity sweep or the union link of root b under root a
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = cnt_q;
		if (state_q == ST_CLEAR) begin
			ram_we = 1'b1;
		end else if (link) begin
			ram_we    = 1'b1;
			ram_waddr = node_q;
			ram_wdata = root_a_q;
		end
	end

	dswc_parent_ram #(
		.DEPTH(MAX_CELLS),
		.AW   (AW)
	) u_parent_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(node_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			cnt_q      <= '0;
			clr_item_q <= 1'b0;
			node_q     <= '0;
			root_a_q   <= '0;
			item_q     <= '0;
			done_q     <= 1'b0;
			res_q      <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					// entry i gets i, one entry a cycle
					cnt_q <= cnt_q + AW'(1);
					if (cnt_q == AW'(MAX_CELLS - 1)) begin
						cnt_q      <= '0;
						state_q    <= ST_IDLE;
						clr_item_q <= 1'b0;
						if (clr_item_q) begin
							done_q <= 1'b1;
							res_q  <= '0;
						end
					end
				end
				ST_IDLE: begin
					if (accept) begin
						item_q <= item;
						if (item.mode == MODE_CLEAR) begin
							clr_item_q <= 1'b1;
							cnt_q      <= '0;
							state_q    <= ST_CLEAR;
						end else if (!in_range) begin
							done_q            <= 1'b1;
							res_q.carved      <= 1'b0;
							res_q.carved_cell <= item.cell_a;
							res_q.wall_dir    <= DIR_EAST;
						end else begin
							node_q  <= AW'(item.cell_a);
							state_q <= ST_RD_A;
						end
					end
				end
				ST_RD_A: begin
					state_q <= ST_CK_A;
				end
				ST_CK_A: begin
					if (at_root) begin
						root_a_q <= node_q;
						node_q   <= AW'(item_q.cell_b);
						state_q  <= ST_RD_B;
					end else begin
						node_q  <= ram_rdata;
						state_q <= ST_RD_A;
					end
				end
				ST_RD_B: begin
					state_q <= ST_CK_B;
				end
				ST_CK_B: begin
					if (at_root) begin
						done_q            <= 1'b1;
						res_q.carved      <= link;
						res_q.carved_cell <= item_q.cell_a;
						res_q.wall_dir    <= (link && !east) ? DIR_SOUTH : DIR_EAST;
						state_q           <= ST_IDLE;
					end else begin
						node_q  <= ram_rdata;
						state_q <= ST_RD_B;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// a result only follows work in progress or a transfer just taken
	`DSWC_ASSERT(a_done_after_work, done |-> $past(busy || start), "result without an item")
	// a carved wall must have written its link the cycle before
	`DSWC_ASSERT(a_carve_wrote, (done && result.carved) |-> $past(ram_we), "carve without link write")
	// the root walk never leaves the table
	`DSWC_NEVER(a_node_range, busy && (32'(node_q) >= 32'(MAX_CELLS)), "walk node out of range")

endmodule
